// ===== sv/lapc_pkg.sv =====
package lapc_pkg;

  localparam int IN_W   = 40;
  localparam int OUT_W  = 24;
  localparam int CMD_W  = 2;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_STEP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLAG = 2'd2;

  localparam logic [1:0] REG_DEADBAND  = 2'd0;
  localparam logic [1:0] REG_PROP_SPAN = 2'd1;
  localparam logic [1:0] REG_POWER_MAX = 2'd2;
  localparam logic [1:0] REG_POWER_MIN = 2'd3;

  localparam logic [11:0] DEADBAND_RST  = 12'd8;
  localparam logic [11:0] PROP_SPAN_RST = 12'd200;
  localparam logic [7:0]  POWER_MAX_RST = 8'd255;
  localparam logic [7:0]  POWER_MIN_RST = 8'd80;

  localparam logic [13:0] TIME_SCALE = 14'd10000;
  localparam logic [6:0]  FULL_DUTY  = 7'd100;
  localparam int          POS_W      = 30;
  localparam int          SAMPLE_SHIFT = 20;

  localparam int PDIV_W  = 19;
  localparam int PDIV_DW = 12;
  localparam int FDIV_W  = 30;
  localparam int FDIV_DW = 14;

  typedef struct packed {
    logic [11:0] deadband;
    logic [11:0] proportional_span;
    logic [7:0]  power_max;
    logic [7:0]  power_min;
  } cfg_t;

endpackage

// ===== sv/lapc_div.sv =====
module lapc_div #(
  parameter int W  = 19,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [W-1:0]  quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dq;
  logic [DW-1:0] dvs;
  logic [DW-1:0] rem;
  logic [CW-1:0] count;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // restoring divide, one quotient bit per cycle
  assign shifted  = {rem, dq[W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = shifted >= {1'b0, dvs};
  assign busy     = count != '0;
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      dq  <= {dq[W-2:0], ge};
    end
  end

endmodule

// ===== sv/lapc_regs.sv =====
module lapc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lapc_pkg::APB_AW-1:0]  paddr,
  input  logic [lapc_pkg::APB_DW-1:0]  pwdata,
  output logic [lapc_pkg::APB_DW-1:0]  prdata,
  output lapc_pkg::cfg_t               cfg
);

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[lapc_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband          <= lapc_pkg::DEADBAND_RST;
      cfg.proportional_span <= lapc_pkg::PROP_SPAN_RST;
      cfg.power_max         <= lapc_pkg::POWER_MAX_RST;
      cfg.power_min         <= lapc_pkg::POWER_MIN_RST;
    end else if (wr) begin
      unique case (idx)
        lapc_pkg::REG_DEADBAND:  cfg.deadband          <= pwdata[11:0];
        lapc_pkg::REG_PROP_SPAN: cfg.proportional_span <= pwdata[11:0];
        lapc_pkg::REG_POWER_MAX: cfg.power_max         <= pwdata[7:0];
        lapc_pkg::REG_POWER_MIN: cfg.power_min         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lapc_pkg::REG_DEADBAND:  prdata = lapc_pkg::APB_DW'(cfg.deadband);
      lapc_pkg::REG_PROP_SPAN: prdata = lapc_pkg::APB_DW'(cfg.proportional_span);
      lapc_pkg::REG_POWER_MAX: prdata = lapc_pkg::APB_DW'(cfg.power_max);
      lapc_pkg::REG_POWER_MIN: prdata = lapc_pkg::APB_DW'(cfg.power_min);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== sv/linear_actuator_position_controller.sv =====
// Position loop for a linear actuator: one input word per control step, one result word back.
// Commands: control step, initialize the filter from the ADC sample (drive stops), or write the
// completion flag. A control step compares the target with the previous filtered position,
// starts or stops the drive, computes the next step's power, and advances the first-order
// position filter. One item is processed at a time. A control step always runs the 30-bit
// bit-serial divide of the filter; when the drive runs, the power mapping adds 19-bit serial
// divides, one for the scaled duty when the error lies inside the proportional span and one
// for the mapping whenever that duty is nonzero. Initialize, flag and unused commands need no
// divide and go straight to output. The next word is accepted from the cycle after the result
// is issued. A new word is accepted while the previous result still waits on the output
// register; the result of that word then stalls until the output register frees.
// Registers sit at byte addresses 0 (deadband), 4 (proportional span), 8 (power max) and
// 12 (power min) and should be written only while the block is idle.
module linear_actuator_position_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] target, [21:12] feedback_sample, [35:22] elapsed_us, [36] complete_value
  input  logic [lapc_pkg::IN_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [lapc_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] extend_dir, [8:1] drive_duty, [9] moving, [10] movement_done,
  // [22:11] position_estimate
  output logic [lapc_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lapc_pkg::APB_AW-1:0]   paddr,
  input  logic [lapc_pkg::APB_DW-1:0]   pwdata,
  output logic [lapc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_PDIV, ST_MAP, ST_MDIV, ST_FWAIT, ST_FUPD, ST_OUT
  } state_t;

  state_t state;

  lapc_pkg::cfg_t cfg;

  logic [lapc_pkg::CMD_W-1:0] cmd;
  logic [11:0] target;
  logic [9:0]  sample;
  logic [13:0] dt;
  logic        cval;

  logic [lapc_pkg::POS_W-1:0] pos;
  logic        dir;
  logic        en;
  logic        done_flag;
  logic [7:0]  next_power;
  logic [7:0]  applied;
  logic [6:0]  duty;
  logic        fneg;
  logic [30:0] fprod;

  logic [11:0] pos12;
  logic [12:0] err;
  logic [12:0] err_neg;
  logic [11:0] mag;
  logic        run;
  logic        prop;
  logic [18:0] mag100;
  logic [lapc_pkg::POS_W-1:0] fin;
  logic [30:0] fdiff;
  logic [30:0] fdiff_neg;
  logic [lapc_pkg::POS_W-1:0] fdiff_mag;
  logic        sneg;
  logic [7:0]  smag;
  logic [18:0] mprod;
  logic [7:0]  mapped;
  logic [13:0] dt_in;

  logic                         pdiv_start;
  logic [lapc_pkg::PDIV_W-1:0]  pdiv_dividend;
  logic [lapc_pkg::PDIV_DW-1:0] pdiv_divisor;
  logic                         pdiv_busy;
  logic [lapc_pkg::PDIV_W-1:0]  pdiv_q;
  logic                         fdiv_start;
  logic                         fdiv_busy;
  logic [lapc_pkg::FDIV_W-1:0]  fdiv_q;

  assign pready        = 1'b1;
  assign s_axis_tready = state == ST_IDLE;

  lapc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pos12   = pos[lapc_pkg::POS_W-1:18];
  assign err     = {1'b0, target} - {1'b0, pos12};
  assign err_neg = 13'd0 - err;
  assign mag     = err[12] ? err_neg[11:0] : err[11:0];
  assign run     = mag > cfg.deadband;
  assign prop    = (cfg.proportional_span != 12'd0) && (mag <= cfg.proportional_span);
  assign mag100  = 19'(mag) * 19'(lapc_pkg::FULL_DUTY);

  assign fin       = {sample, 20'd0};
  assign fdiff     = {1'b0, fin} - {1'b0, pos};
  assign fdiff_neg = 31'd0 - fdiff;
  assign fdiff_mag = fdiff[30] ? fdiff_neg[29:0] : fdiff[29:0];

  assign sneg   = cfg.power_min > cfg.power_max;
  assign smag   = sneg ? cfg.power_min - cfg.power_max : cfg.power_max - cfg.power_min;
  assign mprod  = 19'(duty) * 19'(smag);
  assign mapped = sneg ? cfg.power_min - pdiv_q[7:0] : cfg.power_min + pdiv_q[7:0];

  assign dt_in = (s_axis_tdata[35:22] > lapc_pkg::TIME_SCALE) ?
                 lapc_pkg::TIME_SCALE : s_axis_tdata[35:22];

  assign pdiv_start = (state == ST_EVAL && cmd == lapc_pkg::CMD_STEP && run && prop) ||
                      (state == ST_MAP && duty != 7'd0);
  assign pdiv_dividend = (state == ST_EVAL) ? mag100 : mprod;
  assign pdiv_divisor  = (state == ST_EVAL) ? cfg.proportional_span :
                         lapc_pkg::PDIV_DW'(lapc_pkg::FULL_DUTY);
  assign fdiv_start    = state == ST_EVAL && cmd == lapc_pkg::CMD_STEP;

  lapc_div #(.W(lapc_pkg::PDIV_W), .DW(lapc_pkg::PDIV_DW)) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (pdiv_start),
    .dividend (pdiv_dividend),
    .divisor  (pdiv_divisor),
    .busy     (pdiv_busy),
    .quotient (pdiv_q)
  );

  lapc_div #(.W(lapc_pkg::FDIV_W), .DW(lapc_pkg::FDIV_DW)) u_fdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (fdiv_start),
    .dividend (fdiff_mag),
    .divisor  (lapc_pkg::TIME_SCALE),
    .busy     (fdiv_busy),
    .quotient (fdiv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      pos           <= '0;
      dir           <= 1'b0;
      en            <= 1'b0;
      done_flag     <= 1'b0;
      next_power    <= '0;
      applied       <= '0;
    end else begin
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd    <= s_axis_tuser;
            target <= s_axis_tdata[11:0];
            sample <= s_axis_tdata[21:12];
            dt     <= dt_in;
            cval   <= s_axis_tdata[36];
            state  <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          unique case (cmd)
            lapc_pkg::CMD_STEP: begin
              fneg <= fdiff[30];
              if (run) begin
                dir     <= ~err[12];
                en      <= 1'b1;
                applied <= next_power;
                if (prop) begin
                  state <= ST_PDIV;
                end else begin
                  duty  <= lapc_pkg::FULL_DUTY;
                  state <= ST_MAP;
                end
              end else begin
                if (en) begin
                  en        <= 1'b0;
                  applied   <= '0;
                  done_flag <= 1'b1;
                end
                state <= ST_FWAIT;
              end
            end
            lapc_pkg::CMD_INIT: begin
              dir     <= 1'b0;
              en      <= 1'b0;
              applied <= '0;
              pos     <= fin;
              state   <= ST_OUT;
            end
            lapc_pkg::CMD_FLAG: begin
              done_flag <= cval;
              state     <= ST_OUT;
            end
            default: state <= ST_OUT;
          endcase
        end
        ST_PDIV: begin
          if (!pdiv_busy) begin
            duty  <= pdiv_q[6:0];
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (duty == 7'd0) begin
            next_power <= '0;
            state      <= ST_FWAIT;
          end else begin
            state <= ST_MDIV;
          end
        end
        ST_MDIV: begin
          if (!pdiv_busy) begin
            next_power <= mapped;
            state      <= ST_FWAIT;
          end
        end
        ST_FWAIT: begin
          if (!fdiv_busy) begin
            fprod <= 31'(fdiv_q[16:0]) * 31'(dt);
            state <= ST_FUPD;
          end
        end
        ST_FUPD: begin
          pos   <= fneg ? pos - fprod[29:0] : pos + fprod[29:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {1'b0, pos12, done_flag, en, applied, dir};
            state         <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pdiv_busy && !fdiv_busy)
    else $error("divider still busy while idle");

  a_stopped_duty: assert property (@(posedge clk) disable iff (rst)
    !en |-> applied == 8'd0)
    else $error("duty applied with drive disabled");

  a_pos_write: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(pos) |-> $past(state == ST_FUPD || state == ST_EVAL))
    else $error("position changed outside update");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_OUT))
    else $error("result word without a finished step");

endmodule

// ===== tb/tb_linear_actuator_position_controller.sv =====
module tb_linear_actuator_position_controller;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 240;
  localparam int         HOLD_CYCLES = 400;

  class actuator_scoreboard;
    logic [11:0] deadband;
    logic [11:0] proportional_span;
    logic [7:0]  power_max;
    logic [7:0]  power_min;
    longint      pos;
    bit          dir;
    bit          en;
    bit          flag;
    logic [7:0]  next_power;
    logic [7:0]  duty;
    logic [22:0] expected_drive[$];
    int          errors;

    function new();
      deadband          = lapc_pkg::DEADBAND_RST;
      proportional_span = lapc_pkg::PROP_SPAN_RST;
      power_max         = lapc_pkg::POWER_MAX_RST;
      power_min         = lapc_pkg::POWER_MIN_RST;
      pos        = 0;
      dir        = 0;
      en         = 0;
      flag       = 0;
      next_power = 0;
      duty       = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        lapc_pkg::REG_DEADBAND:  deadband = val[11:0];
        lapc_pkg::REG_PROP_SPAN: proportional_span = val[11:0];
        lapc_pkg::REG_POWER_MAX: power_max = val[7:0];
        lapc_pkg::REG_POWER_MIN: power_min = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [11:0] pos12();
      return pos[29:18];
    endfunction

    // percent demand onto power_min..power_max, truncating toward zero
    function logic [7:0] map_duty(int pct);
      int full, hi, lo;
      full = lapc_pkg::FULL_DUTY;
      hi   = power_max;
      lo   = power_min;
      if (pct <= 0 || pct > full) return 8'd0;
      return 8'((pct * (hi - lo)) / full + lo);
    endfunction

    function void note_command(logic [1:0] cmd, logic [11:0] target, logic [9:0] sample,
                               logic [13:0] elapsed, logic cval);
      int         err, mag, db, span, tgt_i, full;
      logic [7:0] carried;
      longint     sample_pos, dt, scale;
      scale = lapc_pkg::TIME_SCALE;
      dt    = elapsed;
      if (dt > scale) dt = scale;
      sample_pos = sample;
      sample_pos = sample_pos <<< lapc_pkg::SAMPLE_SHIFT;
      case (cmd)
        lapc_pkg::CMD_STEP: begin
          tgt_i   = target;
          err     = pos12();
          err     = tgt_i - err;
          mag     = (err < 0) ? -err : err;
          db      = deadband;
          span    = proportional_span;
          full    = lapc_pkg::FULL_DUTY;
          carried = next_power;
          if (mag > db) begin
            dir  = (err > 0);
            en   = 1;
            duty = carried;
          end
          if (en && mag <= db) begin
            en   = 0;
            duty = 0;
            flag = 1;
          end
          if (en) begin
            if (span != 0 && mag <= span) next_power = map_duty((mag * full) / span);
            else next_power = map_duty(full);
          end
          pos = pos + ((sample_pos - pos) / scale) * dt;
        end
        lapc_pkg::CMD_INIT: begin
          dir  = 0;
          en   = 0;
          duty = 0;
          pos  = sample_pos;
        end
        lapc_pkg::CMD_FLAG: flag = cval;
        default: ;
      endcase
      expected_drive.push_back({pos12(), flag, en, duty, dir});
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_drive(logic [lapc_pkg::OUT_W-1:0] word);
      logic [22:0] want;
      if (expected_drive.size() == 0) begin
        $error("result word %h with nothing expected", word);
        errors++;
        return;
      end
      want = expected_drive.pop_front();
      compare_field("extend_dir", want[0], word[0]);
      compare_field("drive_duty", want[8:1], word[8:1]);
      compare_field("moving", want[9], word[9]);
      compare_field("movement_done", want[10], word[10]);
      compare_field("position_estimate", want[22:11], word[22:11]);
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  // [11:0] target, [21:12] feedback_sample, [35:22] elapsed_us, [36] complete_value
  logic [lapc_pkg::IN_W-1:0]   s_axis_tdata;
  // [1:0] command
  logic [lapc_pkg::CMD_W-1:0]  s_axis_tuser;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  // [0] extend_dir, [8:1] drive_duty, [9] moving, [10] movement_done,
  // [22:11] position_estimate
  logic [lapc_pkg::OUT_W-1:0]  m_axis_tdata;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lapc_pkg::APB_AW-1:0] paddr;
  logic [lapc_pkg::APB_DW-1:0] pwdata;
  logic [lapc_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  actuator_scoreboard sb = new();
  bit quiet       = 0;
  bit hold_output = 0;
  int cycles      = 0;

  linear_actuator_position_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata);
  end

  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        m_axis_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [11:0] tgt, logic [9:0] smp,
                           logic [13:0] dt, logic cv);
    while (!quiet && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, cv, dt, smp, tgt};
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(cmd, tgt, smp, dt, cv);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_drive.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(logic [11:0] db, logic [11:0] span, logic [7:0] hi,
                               logic [7:0] lo);
    logic [31:0] vals[4];
    vals[lapc_pkg::REG_DEADBAND]  = 32'(db);
    vals[lapc_pkg::REG_PROP_SPAN] = 32'(span);
    vals[lapc_pkg::REG_POWER_MAX] = 32'(hi);
    vals[lapc_pkg::REG_POWER_MIN] = 32'(lo);
    for (int r = 0; r < 4; r++) begin
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= {r[1:0], 2'b00};
      pwdata  <= vals[r[1:0]];
      @(negedge clk);
      penable <= 1;
      do @(posedge clk); while (!pready);
      sb.set_reg(r[1:0], vals[r[1:0]]);
      @(negedge clk);
    end
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // mostly targets near the tracked position, samples near the target
  task automatic send_random();
    int          pick, tgt, smp, off, db, reach;
    logic [1:0]  cmd;
    logic [13:0] dt;
    pick = $urandom_range(99);
    if (pick < 8) cmd = lapc_pkg::CMD_INIT;
    else if (pick < 13) cmd = lapc_pkg::CMD_FLAG;
    else if (pick < 16) cmd = CMD_SPARE;
    else cmd = lapc_pkg::CMD_STEP;
    db    = sb.deadband;
    reach = sb.proportional_span;
    reach = reach + db + 2;
    pick  = $urandom_range(99);
    if (pick < 40) begin
      off = $urandom_range(2 * db + 4);
      tgt = sb.pos12();
      tgt = tgt + off - db - 2;
    end else if (pick < 70) begin
      off = $urandom_range(2 * reach);
      tgt = sb.pos12();
      tgt = tgt + off - reach;
    end else begin
      tgt = $urandom_range(4095);
    end
    if (tgt < 0) tgt = 0;
    if (tgt > 4095) tgt = 4095;
    if ($urandom_range(99) < 60) begin
      off = $urandom_range(8);
      smp = tgt / 4 + off - 4;
    end else begin
      smp = $urandom_range(1023);
    end
    if (smp < 0) smp = 0;
    if (smp > 1023) smp = 1023;
    pick = $urandom_range(99);
    if (pick < 60) dt = 14'($urandom_range(10000));
    else if (pick < 75) dt = 14'($urandom_range(16383, 10001));
    else if (pick < 90) dt = 14'($urandom_range(200));
    else dt = 14'($urandom_range(16383));
    send_word(cmd, tgt[11:0], smp[9:0], dt, 1'($urandom_range(1)));
  endtask

  initial begin
    rst           = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lapc_pkg::CMD_STEP;
    psel          = 0;
    penable       = 0;
    pwrite        = 0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset settings: band edges, stop and flag, held-state commands, clamp
    send_word(lapc_pkg::CMD_STEP, 12'd0,    10'd0,    14'd0,     1'b0);
    send_word(lapc_pkg::CMD_FLAG, 12'd0,    10'd0,    14'd0,     1'b1);
    send_word(CMD_SPARE,          12'd0,    10'd0,    14'd0,     1'b0);
    send_word(lapc_pkg::CMD_FLAG, 12'd0,    10'd0,    14'd0,     1'b0);
    send_word(lapc_pkg::CMD_INIT, 12'd0,    10'd1023, 14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd0,    10'd1023, 14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd3992, 10'd1023, 14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4083, 10'd1023, 14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4084, 10'd1023, 14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4092, 10'd1023, 14'd0,     1'b0);
    send_word(lapc_pkg::CMD_FLAG, 12'd0,    10'd0,    14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4095, 10'd0,    14'd16383, 1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4095, 10'd1023, 14'd10000, 1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4095, 10'd512,  14'd10001, 1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd2048, 10'd341,  14'd8192,  1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd1365, 10'd682,  14'd1,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd2730, 10'd0,    14'd9999,  1'b0);
    send_word(lapc_pkg::CMD_INIT, 12'd0,    10'd0,    14'd0,     1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'd4095, 10'd1023, 14'd4096,  1'b1);
    send_word(lapc_pkg::CMD_STEP, 12'd0,    10'd0,    14'd16383, 1'b1);
    send_word(CMD_SPARE,          12'd4095, 10'd1023, 14'd16383, 1'b1);
    send_word(lapc_pkg::CMD_FLAG, 12'd4095, 10'd1023, 14'd16383, 1'b1);
    send_word(lapc_pkg::CMD_STEP, 12'haaa,  10'h2aa,  14'h2aaa,  1'b0);
    send_word(lapc_pkg::CMD_STEP, 12'h555,  10'h155,  14'h1555,  1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: load_settings(12'd0, 12'd1, 8'd255, 8'd0);
        1: load_settings(12'd4095, 12'd4095, 8'd0, 8'd255);
        2: load_settings(12'd0, 12'd0, 8'd200, 8'd100);
        3: load_settings(lapc_pkg::DEADBAND_RST, lapc_pkg::PROP_SPAN_RST,
                         lapc_pkg::POWER_MAX_RST, lapc_pkg::POWER_MIN_RST);
        4: load_settings(12'd3, 12'd4095, 8'd10, 8'd250);
        default: load_settings(12'($urandom_range(100)), 12'($urandom_range(4095)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      quiet = (phase == 3);
      if (phase == 5) hold_output = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
